// ===== rtl/crcfb_pkg.sv =====
// shared types, constants and the crc byte step for the crc16 frame builder
package crcfb_pkg;

   // crc-16 parameters, msb first, no reflection, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // bytes a frame carries besides its payload
   localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

   // result status codes
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE     = 2'd1;
   localparam logic [1:0] STATUS_NOT_IN_FRAME = 2'd2;

   // input item modes
   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_FIRST    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_SECOND   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION_BYTE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LEN = 2'd3;

   // configuration reset values
   localparam logic [7:0]  HEAD_FIRST_RESET    = 8'hFA;
   localparam logic [7:0]  HEAD_SECOND_RESET   = 8'hFC;
   localparam logic [7:0]  VERSION_BYTE_RESET  = 8'h01;
   localparam logic [16:0] MAX_FRAME_LEN_RESET = 17'd65543;

   // beat index within a header run
   localparam logic [2:0] HDR_HEAD_FIRST  = 3'd0;
   localparam logic [2:0] HDR_HEAD_SECOND = 3'd1;
   localparam logic [2:0] HDR_VERSION     = 3'd2;
   localparam logic [2:0] HDR_COMMAND     = 3'd3;
   localparam logic [2:0] HDR_LEN_HI      = 3'd4;
   localparam logic [2:0] HDR_LEN_LO      = 3'd5;
   localparam logic [2:0] HDR_CRC_HI      = 3'd6;
   localparam logic [2:0] HDR_CRC_LO      = 3'd7;

   // beat index within a payload run
   localparam logic [2:0] DAT_BYTE   = 3'd0;
   localparam logic [2:0] DAT_CRC_HI = 3'd1;
   localparam logic [2:0] DAT_CRC_LO = 3'd2;

   typedef enum logic [1:0] {
      JOB_REFUSE,
      JOB_NOT_IN_FRAME,
      JOB_HEADER,
      JOB_DATA
   } job_kind_type;

   // one classified item handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_val;   // command for a header, payload byte for data
      logic [15:0]  plen;
      logic [15:0]  crc;
      logic [16:0]  total;
      logic         close;      // crc bytes follow this run
   } job_type;

   typedef struct packed {
      logic [7:0]  head_first;
      logic [7:0]  head_second;
      logic [7:0]  version_byte;
      logic [16:0] max_frame_len;
   } cfg_type;

   // queue handshake between front, queue and back
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   // one byte through the crc, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/crcfb_if.sv =====
// request and response channel interfaces of the crc16 frame builder

interface crcfb_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  command;
   logic [15:0] payload_len;
   logic [7:0]  data_byte;

   modport source (output valid, output mode, output command, output payload_len,
                   output data_byte, input ready);
   modport sink   (input valid, input mode, input command, input payload_len,
                   input data_byte, output ready);
endinterface

interface crcfb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  status;
   logic        run_last;
   logic        frame_end;
   logic [16:0] frame_len;

   modport source (output valid, output out_byte, output status, output run_last,
                   output frame_end, output frame_len, input ready);
   modport sink   (input valid, input out_byte, input status, input run_last,
                   input frame_end, input frame_len, output ready);
endinterface

// ===== rtl/crc16_frame_builder_core.sv =====
// top level of the crc16 frame builder: csr file, front end, job queue and back end
//
// Builds serial frames of head bytes, version, command, big-endian length, payload
// and a big-endian CRC-16 (init 0xFFFF, poly 0x1021) over command, length and
// payload. Payload and error items are taken one per cycle while the front end is
// idle and the queue has space; a payload byte gives one result beat, three with the
// crc when it closes the frame, one beat per cycle while the receiver is ready.
// A taken byte goes through a queue entry, the job register and the output register.
// A start item holds the request channel while the front end runs the crc over the
// command and both length bytes, one byte a cycle unless the queue is full; its six
// or eight header beats drain at one beat a cycle while the receiver is ready, so
// requests stall once the QUEUE_DEPTH job queue fills behind a header run. The user
// must write the csr registers only while no item is in flight; it is not enforced.
module crc16_frame_builder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crcfb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crcfb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   crcfb_req_if.sink                          req_bus,
   crcfb_rsp_if.source                        rsp_bus
);

   crcfb_pkg::cfg_type          cfg_ff, cfg_in;
   crcfb_pkg::queue_status_type q_status;
   crcfb_pkg::job_type          push_job;
   crcfb_pkg::job_type          pop_job;
   logic                        push;
   logic                        pop;

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            crcfb_pkg::CSR_HEAD_FIRST:    cfg_in.head_first   = csr_wdata[7:0];
            crcfb_pkg::CSR_HEAD_SECOND:   cfg_in.head_second  = csr_wdata[7:0];
            crcfb_pkg::CSR_VERSION_BYTE:  cfg_in.version_byte = csr_wdata[7:0];
            crcfb_pkg::CSR_MAX_FRAME_LEN: cfg_in.max_frame_len = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_first    <= crcfb_pkg::HEAD_FIRST_RESET;
         cfg_ff.head_second   <= crcfb_pkg::HEAD_SECOND_RESET;
         cfg_ff.version_byte  <= crcfb_pkg::VERSION_BYTE_RESET;
         cfg_ff.max_frame_len <= crcfb_pkg::MAX_FRAME_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   crcfb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // job queue
   crcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_status (q_status)
   );

   // back end
   crcfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .pop_job  (pop_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== rtl/crcfb_front.sv =====
// front end: accepts request beats, keeps frame state and crc, classifies into jobs
module crcfb_front (
   input  logic                       clock,
   input  logic                       reset,
   crcfb_req_if.sink                  req_bus,
   input  crcfb_pkg::cfg_type         cfg,
   input  crcfb_pkg::queue_status_type q_status,
   output logic                       push,
   output crcfb_pkg::job_type         push_job
);

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_LEN_HI,
      FRONT_LEN_LO
   } front_state_type;

   front_state_type state_ff, state_in;
   logic            in_frame_ff, in_frame_in;
   logic [15:0]     bytes_left_ff, bytes_left_in;
   logic [15:0]     crc_ff, crc_in;
   logic [16:0]     total_ff, total_in;
   logic [7:0]      cmd_ff, cmd_in;
   logic [15:0]     plen_ff, plen_in;

   logic            accept;
   logic [16:0]     start_total;
   logic [15:0]     crc_step;

   assign req_bus.ready = (state_ff == FRONT_IDLE) && !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign start_total   = crcfb_pkg::FRAME_OVERHEAD + {1'b0, req_bus.payload_len};

   // classify the item and step the frame state
   always_comb begin
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      total_in      = total_ff;
      cmd_in        = cmd_ff;
      plen_in       = plen_ff;
      push          = 1'b0;
      crc_step      = '0;
      push_job      = '{kind: crcfb_pkg::JOB_NOT_IN_FRAME, byte_val: 8'h00, plen: 16'h0000,
                        crc: 16'h0000, total: 17'd0, close: 1'b0};
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               if (req_bus.mode == crcfb_pkg::MODE_START) begin
                  if (start_total > cfg.max_frame_len) begin
                     push           = 1'b1;
                     push_job.kind  = crcfb_pkg::JOB_REFUSE;
                     push_job.total = start_total;
                  end else begin
                     cmd_in        = req_bus.command;
                     plen_in       = req_bus.payload_len;
                     total_in      = start_total;
                     crc_in        = crcfb_pkg::crc_byte(crcfb_pkg::CRC_INIT, req_bus.command);
                     in_frame_in   = (req_bus.payload_len != 16'h0000);
                     bytes_left_in = req_bus.payload_len;
                     state_in      = FRONT_LEN_HI;
                  end
               end else if (!in_frame_ff) begin
                  push          = 1'b1;
                  push_job.kind = crcfb_pkg::JOB_NOT_IN_FRAME;
               end else begin
                  crc_step          = crcfb_pkg::crc_byte(crc_ff, req_bus.data_byte);
                  crc_in            = crc_step;
                  bytes_left_in     = bytes_left_ff - 16'd1;
                  push              = 1'b1;
                  push_job.kind     = crcfb_pkg::JOB_DATA;
                  push_job.byte_val = req_bus.data_byte;
                  push_job.crc      = crc_step;
                  push_job.total    = total_ff;
                  push_job.close    = (bytes_left_ff == 16'd1);
                  if (bytes_left_ff == 16'd1) begin
                     in_frame_in = 1'b0;
                  end
               end
            end
         end
         FRONT_LEN_HI: begin
            crc_in   = crcfb_pkg::crc_byte(crc_ff, plen_ff[15:8]);
            state_in = FRONT_LEN_LO;
         end
         FRONT_LEN_LO: begin
            if (!q_status.full) begin
               crc_step          = crcfb_pkg::crc_byte(crc_ff, plen_ff[7:0]);
               crc_in            = crc_step;
               push              = 1'b1;
               push_job.kind     = crcfb_pkg::JOB_HEADER;
               push_job.byte_val = cmd_ff;
               push_job.plen     = plen_ff;
               push_job.crc      = crc_step;
               push_job.total    = total_ff;
               push_job.close    = (plen_ff == 16'h0000);
               state_in          = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // state and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FRONT_IDLE;
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= 16'h0000;
         crc_ff        <= crcfb_pkg::CRC_INIT;
         total_ff      <= 17'd0;
         cmd_ff        <= 8'h00;
         plen_ff       <= 16'h0000;
      end else begin
         state_ff      <= state_in;
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         total_ff      <= total_in;
         cmd_ff        <= cmd_in;
         plen_ff       <= plen_in;
      end
   end

   // a frame in progress always has bytes to come
   assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (bytes_left_ff != 16'h0000))
      else $error("front: open frame with no bytes left");

   // the high length crc step is always followed by the low length step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FRONT_LEN_HI) |=> (state_ff == FRONT_LEN_LO))
      else $error("front: length crc step skipped");

   // nothing is pushed into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("front: push into full queue");

endmodule

// ===== rtl/crcfb_queue.sv =====
// short register queue of jobs between front and back
module crcfb_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  crcfb_pkg::job_type          push_job,
   input  logic                        pop,
   output crcfb_pkg::job_type          pop_job,
   output crcfb_pkg::queue_status_type q_status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   crcfb_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign pop_job        = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // never popped while empty
   assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("queue: pop from empty queue");

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue: fill count overflow");

   // read and write pointers meet only when empty or full
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (!q_status.valid || q_status.full))
      else $error("queue: pointers disagree with fill count");

endmodule

// ===== rtl/crcfb_back.sv =====
// back end: expands each job into its run of result beats through an output register
module crcfb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  crcfb_pkg::cfg_type          cfg,
   input  crcfb_pkg::queue_status_type q_status,
   input  crcfb_pkg::job_type          pop_job,
   output logic                        pop,
   crcfb_rsp_if.source                 rsp_bus
);

   logic               active_ff, active_in;
   crcfb_pkg::job_type job_ff, job_in;
   logic [2:0]         idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic [1:0]         status_ff, status_in;
   logic               run_last_ff, run_last_in;
   logic               frame_end_ff, frame_end_in;
   logic [16:0]        frame_len_ff, frame_len_in;

   logic [2:0]         last_idx;
   logic               out_free;
   logic               emit;
   logic               job_done;
   logic [7:0]         beat_byte;
   logic [1:0]         beat_status;

   // run length of the current job
   always_comb begin
      case (job_ff.kind)
         crcfb_pkg::JOB_HEADER: last_idx = job_ff.close ? crcfb_pkg::HDR_CRC_LO
                                                        : crcfb_pkg::HDR_LEN_LO;
         crcfb_pkg::JOB_DATA:   last_idx = job_ff.close ? crcfb_pkg::DAT_CRC_LO
                                                        : crcfb_pkg::DAT_BYTE;
         default:               last_idx = 3'd0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = active_ff && out_free;
   assign job_done = emit && (idx_ff == last_idx);
   assign pop      = q_status.valid && (!active_ff || job_done);

   // byte and status of the current beat
   always_comb begin
      beat_byte   = 8'h00;
      beat_status = crcfb_pkg::STATUS_OK;
      case (job_ff.kind)
         crcfb_pkg::JOB_REFUSE: begin
            beat_status = crcfb_pkg::STATUS_NO_SPACE;
         end
         crcfb_pkg::JOB_NOT_IN_FRAME: begin
            beat_status = crcfb_pkg::STATUS_NOT_IN_FRAME;
         end
         crcfb_pkg::JOB_HEADER: begin
            case (idx_ff)
               crcfb_pkg::HDR_HEAD_FIRST:  beat_byte = cfg.head_first;
               crcfb_pkg::HDR_HEAD_SECOND: beat_byte = cfg.head_second;
               crcfb_pkg::HDR_VERSION:     beat_byte = cfg.version_byte;
               crcfb_pkg::HDR_COMMAND:     beat_byte = job_ff.byte_val;
               crcfb_pkg::HDR_LEN_HI:      beat_byte = job_ff.plen[15:8];
               crcfb_pkg::HDR_LEN_LO:      beat_byte = job_ff.plen[7:0];
               crcfb_pkg::HDR_CRC_HI:      beat_byte = job_ff.crc[15:8];
               default:                    beat_byte = job_ff.crc[7:0];
            endcase
         end
         default: begin
            case (idx_ff)
               crcfb_pkg::DAT_BYTE:   beat_byte = job_ff.byte_val;
               crcfb_pkg::DAT_CRC_HI: beat_byte = job_ff.crc[15:8];
               default:               beat_byte = job_ff.crc[7:0];
            endcase
         end
      endcase
   end

   // job sequencing and output register load
   always_comb begin
      active_in    = active_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      status_in    = status_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      frame_len_in = frame_len_ff;

      if (pop) begin
         active_in = 1'b1;
         job_in    = pop_job;
         idx_in    = 3'd0;
      end else if (job_done) begin
         active_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = beat_byte;
         status_in    = beat_status;
         run_last_in  = (idx_ff == last_idx);
         frame_end_in = job_ff.close && (idx_ff == last_idx) &&
                        ((job_ff.kind == crcfb_pkg::JOB_HEADER) ||
                         (job_ff.kind == crcfb_pkg::JOB_DATA));
         frame_len_in = job_ff.total;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      out_byte_ff  <= out_byte_in;
      status_ff    <= status_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
      frame_len_ff <= frame_len_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_byte  = out_byte_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.run_last  = run_last_ff;
   assign rsp_bus.frame_end = frame_end_ff;
   assign rsp_bus.frame_len = frame_len_ff;

   // the final crc byte closes its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> run_last_ff)
      else $error("back: frame end not on last beat of run");

   // error beats stand alone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != crcfb_pkg::STATUS_OK)) |-> run_last_ff)
      else $error("back: error beat not last of run");

   // beat index stays inside the run
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_idx))
      else $error("back: beat index beyond run");

endmodule

// ===== tb/tb_crc16_frame_builder_core.sv =====
// self-checking testbench for crc16_frame_builder_core with random bursts and stalls
module tb_crc16_frame_builder_core;

   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned HOLD_CYCLES   = 150;
   localparam int unsigned STALL_LIMIT   = 3000;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_ITEMS   = 125;

   // one request beat as the sender queues it
   typedef struct packed {
      logic        mode;
      logic [7:0]  command;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
   } req_item_type;

   // one expected response beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic        run_last;
      logic        frame_end;
      logic [16:0] frame_len;
   } frame_beat_type;

   // receiver ready patterns
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_THREE_OF_FOUR,
      RX_SPARSE
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [crcfb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [crcfb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   crcfb_req_if req_bus ();
   crcfb_rsp_if rsp_bus ();

   crc16_frame_builder_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #10 clock = ~clock;

   // stimulus and expected beats
   req_item_type   pending_items[$];
   frame_beat_type frame_beats_due[$];
   int unsigned items_queued = 0;
   int unsigned items_taken  = 0;
   int unsigned fail_count   = 0;

   // shadow of the csr file
   logic [7:0]  hdr_first   = crcfb_pkg::HEAD_FIRST_RESET;
   logic [7:0]  hdr_second  = crcfb_pkg::HEAD_SECOND_RESET;
   logic [7:0]  hdr_version = crcfb_pkg::VERSION_BYTE_RESET;
   logic [16:0] len_limit   = crcfb_pkg::MAX_FRAME_LEN_RESET;

   // framer state as predicted
   logic        fb_in_frame = 1'b0;
   logic [15:0] fb_left     = 16'd0;
   logic [15:0] fb_crc      = crcfb_pkg::CRC_INIT;
   logic [16:0] fb_total    = 17'd0;

   // receiver hold-off request, toggled by the stimulus side
   logic [3:0] hold_ask  = '0;
   logic [3:0] hold_seen = '0;

   // crc-16 ccitt, one data bit per step, msb first
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0} ^ (fb ? crcfb_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic frame_beat_type mk_beat(input logic [7:0] b, input logic [1:0] st,
                                              input logic fend, input logic [16:0] len);
      frame_beat_type f;
      f.out_byte  = b;
      f.status    = st;
      f.run_last  = 1'b0;
      f.frame_end = fend;
      f.frame_len = len;
      return f;
   endfunction

   // work out the beats one accepted request causes and advance the framer state
   function automatic void build_frame_beats(input logic mode, input logic [7:0] cmd,
                                             input logic [15:0] plen, input logic [7:0] data);
      frame_beat_type run[$];
      frame_beat_type tail;
      logic [16:0] total;
      logic [15:0] crc;
      if (mode == crcfb_pkg::MODE_START) begin
         total = crcfb_pkg::FRAME_OVERHEAD + {1'b0, plen};
         if (total > len_limit) begin
            // refused start leaves any open frame untouched
            run.push_back(mk_beat(8'h00, crcfb_pkg::STATUS_NO_SPACE, 1'b0, total));
         end else begin
            crc      = crc_step(crc_step(crc_step(crcfb_pkg::CRC_INIT, cmd), plen[15:8]),
                                plen[7:0]);
            fb_total = total;
            fb_crc   = crc;
            run.push_back(mk_beat(hdr_first, crcfb_pkg::STATUS_OK, 1'b0, total));
            run.push_back(mk_beat(hdr_second, crcfb_pkg::STATUS_OK, 1'b0, total));
            run.push_back(mk_beat(hdr_version, crcfb_pkg::STATUS_OK, 1'b0, total));
            run.push_back(mk_beat(cmd, crcfb_pkg::STATUS_OK, 1'b0, total));
            run.push_back(mk_beat(plen[15:8], crcfb_pkg::STATUS_OK, 1'b0, total));
            run.push_back(mk_beat(plen[7:0], crcfb_pkg::STATUS_OK, 1'b0, total));
            if (plen == 16'd0) begin
               run.push_back(mk_beat(crc[15:8], crcfb_pkg::STATUS_OK, 1'b0, total));
               run.push_back(mk_beat(crc[7:0], crcfb_pkg::STATUS_OK, 1'b1, total));
               fb_in_frame = 1'b0;
               fb_left     = 16'd0;
            end else begin
               fb_in_frame = 1'b1;
               fb_left     = plen;
            end
         end
      end else if (!fb_in_frame) begin
         run.push_back(mk_beat(8'h00, crcfb_pkg::STATUS_NOT_IN_FRAME, 1'b0, 17'd0));
      end else begin
         fb_crc = crc_step(fb_crc, data);
         run.push_back(mk_beat(data, crcfb_pkg::STATUS_OK, 1'b0, fb_total));
         fb_left = fb_left - 16'd1;
         if (fb_left == 16'd0) begin
            run.push_back(mk_beat(fb_crc[15:8], crcfb_pkg::STATUS_OK, 1'b0, fb_total));
            run.push_back(mk_beat(fb_crc[7:0], crcfb_pkg::STATUS_OK, 1'b1, fb_total));
            fb_in_frame = 1'b0;
         end
      end
      tail = run.pop_back();
      tail.run_last = 1'b1;
      run.push_back(tail);
      foreach (run[i]) frame_beats_due.push_back(run[i]);
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   // driver: bursts of random length with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : driver
      req_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            build_frame_beats(req_bus.mode, req_bus.command, req_bus.payload_len,
                              req_bus.data_byte);
            items_taken <= items_taken + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt = pending_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.mode        <= nxt.mode;
               req_bus.command     <= nxt.command;
               req_bus.payload_len <= nxt.payload_len;
               req_bus.data_byte   <= nxt.data_byte;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: changing ready patterns plus an occasional long hold-off
   int unsigned    hold_left = 0;
   int unsigned    pat_left  = 0;
   int unsigned    rx_cycle  = 0;
   rx_pattern_type rx_pat    = RX_OPEN;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            rx_pat   = rx_pattern_type'($urandom_range(0, 3));
            pat_left = $urandom_range(8, 64);
         end
         pat_left--;
         rx_cycle++;
         case (rx_pat)
            RX_OPEN:          rsp_bus.ready <= 1'b1;
            RX_COIN:          rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_THREE_OF_FOUR: rsp_bus.ready <= (rx_cycle[1:0] != 2'd0);
            default:          rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // monitor: compare each response beat with the oldest expected beat
   always @(posedge clock) begin : monitor
      frame_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_beats_due.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual byte %0h status %0d len %0d",
                     $time, rsp_bus.out_byte, rsp_bus.status, rsp_bus.frame_len);
            fail_count++;
         end else begin
            want = frame_beats_due.pop_front();
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_bus.out_byte));
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("run_last", 32'(want.run_last), 32'(rsp_bus.run_last));
            check_field("frame_end", 32'(want.frame_end), 32'(rsp_bus.frame_end));
            check_field("frame_len", 32'(want.frame_len), 32'(rsp_bus.frame_len));
         end
      end
   end

   // watchdog: too long without any beat on either channel
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t timeout: no beat for %0d cycles", $time, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus helpers
   task automatic queue_start(input logic [7:0] cmd, input logic [15:0] plen);
      req_item_type it;
      it.mode        = crcfb_pkg::MODE_START;
      it.command     = cmd;
      it.payload_len = plen;
      it.data_byte   = 8'($urandom_range(0, 255));
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_payload(input logic [7:0] data);
      req_item_type it;
      it.mode        = crcfb_pkg::MODE_PAYLOAD;
      it.command     = 8'($urandom_range(0, 255));
      it.payload_len = 16'($urandom_range(0, 65535));
      it.data_byte   = data;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_frame(input logic [15:0] plen, input int unsigned nbytes);
      queue_start(8'($urandom_range(0, 255)), plen);
      repeat (nbytes) queue_payload(8'($urandom_range(0, 255)));
   endtask

   // mostly whole frames, some cut short, some huge ones abandoned, some stray bytes
   task automatic queue_random_phase(input int unsigned n_items);
      int unsigned goal;
      int unsigned len;
      goal = items_queued + n_items;
      while (items_queued < goal) begin
         case ($urandom_range(0, 9))
            0: queue_payload(8'($urandom_range(0, 255)));
            1: begin
               len = $urandom_range(1, 20);
               queue_frame(16'(len), $urandom_range(0, len - 1));
            end
            2: queue_frame(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
            default: begin
               len = $urandom_range(0, 12);
               queue_frame(16'(len), len);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || frame_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [crcfb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [16:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         crcfb_pkg::CSR_HEAD_FIRST:   hdr_first   = val[7:0];
         crcfb_pkg::CSR_HEAD_SECOND:  hdr_second  = val[7:0];
         crcfb_pkg::CSR_VERSION_BYTE: hdr_version = val[7:0];
         default:                     len_limit   = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] hf, input logic [7:0] hs,
                             input logic [7:0] ver, input logic [16:0] lim);
      csr_write(crcfb_pkg::CSR_HEAD_FIRST, {9'd0, hf});
      csr_write(crcfb_pkg::CSR_HEAD_SECOND, {9'd0, hs});
      csr_write(crcfb_pkg::CSR_VERSION_BYTE, {9'd0, ver});
      csr_write(crcfb_pkg::CSR_MAX_FRAME_LEN, lim);
   endtask

   // main sequence
   initial begin
      logic [16:0] lim;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = crcfb_pkg::MODE_START;
      req_bus.command     = 8'h00;
      req_bus.payload_len = 16'h0000;
      req_bus.data_byte   = 8'h00;
      rsp_bus.ready       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stray byte, empty frames, extreme lengths, restart mid-frame
      queue_payload(8'hFF);
      queue_start(8'h00, 16'h0000);
      queue_start(8'hFF, 16'h0000);
      queue_start(8'hA5, 16'd2);
      queue_payload(8'h00);
      queue_payload(8'hFF);
      queue_start(8'h5A, 16'hFFFF);
      queue_start(8'h3C, 16'd1);
      queue_payload(8'h81);
      queue_payload(8'h7E);
      wait_drained();

      // smallest limit: only empty frames fit
      set_config(8'h00, 8'hFF, 8'hAA, 17'd8);
      queue_start(8'h11, 16'd0);
      queue_start(8'h22, 16'd1);
      queue_payload(8'h33);
      wait_drained();

      // refused start inside an open frame lets that frame go on
      set_config(8'hFF, 8'h00, 8'h00, 17'd20);
      queue_start(8'hC3, 16'd5);
      queue_payload(8'h01);
      queue_payload(8'h02);
      queue_start(8'h44, 16'd100);
      queue_payload(8'h03);
      queue_payload(8'h04);
      queue_payload(8'h05);
      wait_drained();

      // random phases under changing settings, one with a long receiver hold-off
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: lim = crcfb_pkg::MAX_FRAME_LEN_RESET;
            1: lim = 17'd8 + 17'($urandom_range(0, 16));
            2: lim = 17'($urandom_range(8, 65543));
            default: lim = 17'd8 + 17'($urandom_range(4, 24));
         endcase
         set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), lim);
         queue_random_phase(PHASE_ITEMS);
         if (p == 1) begin
            @(posedge clock);
            hold_ask <= hold_ask + 4'd1;
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
